>>> sv/ttb_pkg.sv
package ttb_pkg;

  localparam int unsigned NORM_TOP = 30;

  // ctrl -> datapath commands
  typedef enum logic [3:0] {
    OP_NONE     = 4'd0,
    OP_STORE0   = 4'd1,
    OP_STORE1   = 4'd2,
    OP_DELTA    = 4'd3,
    OP_MUL      = 4'd4,
    OP_VEC      = 4'd5,
    OP_NORM_LD  = 4'd6,
    OP_SCALE    = 4'd7,
    OP_SUMSQ    = 4'd8,
    OP_SQRT     = 4'd9,
    OP_DIV_LD   = 4'd10,
    OP_DIV      = 4'd11,
    OP_DIV_ST   = 4'd12,
    OP_OUT      = 4'd13
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       vsel;   // 0: tangent, 1: bitangent
    logic [1:0] comp;   // component index
  } cmd_t;

  typedef struct packed {
    logic det_zero;
    logic vec_zero;
  } stat_t;

endpackage

>>> sv/ttb_datapath.sv
module ttb_datapath import ttb_pkg::*; #(
  parameter int unsigned POS_WIDTH     = 32,
  parameter int unsigned UV_WIDTH      = 16,
  parameter int unsigned OUT_FRAC_BITS = 14
) (
  input  logic                        clk_i,
  input  cmd_t                        cmd_i,
  output stat_t                       stat_o,
  input  logic signed [POS_WIDTH-1:0] pos_x_i,
  input  logic signed [POS_WIDTH-1:0] pos_y_i,
  input  logic signed [POS_WIDTH-1:0] pos_z_i,
  input  logic signed [UV_WIDTH-1:0]  tex_u_i,
  input  logic signed [UV_WIDTH-1:0]  tex_v_i,
  output logic signed [15:0]          res_o [6]
);

  localparam int unsigned EW = POS_WIDTH + 1;       // edge width
  localparam int unsigned DW = UV_WIDTH + 1;        // uv delta width
  localparam int unsigned PW = EW + DW;             // product width
  localparam int unsigned VW = PW + 1;              // vector width
  localparam int unsigned MW = VW;                  // magnitude width
  localparam int unsigned SW = 64;                  // sum of squares
  localparam int unsigned QW = OUT_FRAC_BITS + 2;   // quotient width
  localparam int unsigned NW = NORM_TOP + OUT_FRAC_BITS + 1;
  localparam int unsigned LZW = $clog2(MW + 1);

  logic signed [POS_WIDTH-1:0] p0_q [3], p1_q [3];
  logic signed [UV_WIDTH-1:0]  t0_q [2], t1_q [2];
  logic signed [EW-1:0] e1_q [3], e2_q [3];
  logic signed [DW-1:0] d1u_q, d1v_q, d2u_q, d2v_q;
  logic signed [PW-1:0] pa_q [3], pb_q [3], pc_q [3], pd_q [3];
  logic signed [2*DW:0] det_q;
  logic signed [VW-1:0] tv_q [3], bv_q [3];
  logic        [MW-1:0] mag_q [3];
  logic                 neg_q [3];
  logic        [NORM_TOP-1:0] sm_q [3];
  logic        [SW-1:0] sum_q, rem_q;
  logic        [31:0]   root_q;
  logic        [NW-1:0] num_q;
  logic        [QW-1:0] quo_q;
  logic        [31:0]   drem_q;
  logic signed [15:0]   res_q [6];

  logic signed [POS_WIDTH-1:0] pin [3];
  logic        [MW-1:0] mx;
  logic        [LZW-1:0] bl;
  logic        [SW-1:0] sqterm, trial;
  logic        [32:0]   dtrial;
  logic        [QW-1:0] qsat;
  logic        [2:0]    ridx;

  assign pin[0] = pos_x_i;
  assign pin[1] = pos_y_i;
  assign pin[2] = pos_z_i;

  always_comb begin
    mx = mag_q[0];
    if (mag_q[1] > mx) mx = mag_q[1];
    if (mag_q[2] > mx) mx = mag_q[2];
    bl = '0;
    for (int i = 0; i < MW; i++) begin
      if (mx[i]) bl = LZW'(i + 1);
    end
  end

  assign sqterm = SW'(sm_q[cmd_i.comp]) * SW'(sm_q[cmd_i.comp]);
  assign trial  = {rem_q[SW-3:0], sum_q[SW-1 -: 2]} - {30'd0, root_q, 2'b01};
  assign dtrial = {drem_q, num_q[NW-1]} - {1'b0, root_q};
  assign qsat   = (quo_q > QW'(1 << OUT_FRAC_BITS)) ? QW'(1 << OUT_FRAC_BITS) : quo_q;
  assign ridx   = cmd_i.vsel ? 3'd3 + {1'b0, cmd_i.comp} : {1'b0, cmd_i.comp};

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_STORE0: begin
        for (int i = 0; i < 3; i++) p0_q[i] <= pin[i];
        t0_q[0] <= tex_u_i;
        t0_q[1] <= tex_v_i;
      end
      OP_STORE1: begin
        for (int i = 0; i < 3; i++) p1_q[i] <= pin[i];
        t1_q[0] <= tex_u_i;
        t1_q[1] <= tex_v_i;
      end
      OP_DELTA: begin
        for (int i = 0; i < 3; i++) begin
          e1_q[i] <= EW'(p1_q[i]) - EW'(p0_q[i]);
          e2_q[i] <= EW'(pin[i]) - EW'(p0_q[i]);
        end
        d1u_q <= DW'(t1_q[0]) - DW'(t0_q[0]);
        d1v_q <= DW'(t1_q[1]) - DW'(t0_q[1]);
        d2u_q <= DW'(tex_u_i) - DW'(t0_q[0]);
        d2v_q <= DW'(tex_v_i) - DW'(t0_q[1]);
      end
      OP_MUL: begin
        det_q <= (2*DW+1)'(d1u_q * d2v_q) - (2*DW+1)'(d2u_q * d1v_q);
        for (int i = 0; i < 3; i++) begin
          pa_q[i] <= PW'(d2v_q * e1_q[i]);
          pb_q[i] <= PW'(d1v_q * e2_q[i]);
          pc_q[i] <= PW'(d1u_q * e2_q[i]);
          pd_q[i] <= PW'(d2u_q * e1_q[i]);
        end
      end
      OP_VEC: begin
        for (int i = 0; i < 3; i++) begin
          if (det_q[2*DW]) begin
            tv_q[i] <= VW'(pb_q[i]) - VW'(pa_q[i]);
            bv_q[i] <= VW'(pd_q[i]) - VW'(pc_q[i]);
          end else begin
            tv_q[i] <= VW'(pa_q[i]) - VW'(pb_q[i]);
            bv_q[i] <= VW'(pc_q[i]) - VW'(pd_q[i]);
          end
        end
      end
      OP_NORM_LD: begin
        for (int i = 0; i < 3; i++) begin
          if (cmd_i.vsel) begin
            neg_q[i] <= bv_q[i][VW-1];
            mag_q[i] <= bv_q[i][VW-1] ? MW'(-bv_q[i]) : MW'(bv_q[i]);
          end else begin
            neg_q[i] <= tv_q[i][VW-1];
            mag_q[i] <= tv_q[i][VW-1] ? MW'(-tv_q[i]) : MW'(tv_q[i]);
          end
        end
        sum_q <= '0;
      end
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          if (bl > LZW'(NORM_TOP)) sm_q[i] <= NORM_TOP'(mag_q[i] >> (bl - LZW'(NORM_TOP)));
          else sm_q[i] <= NORM_TOP'(mag_q[i] << (LZW'(NORM_TOP) - bl));
        end
      end
      OP_SUMSQ: begin
        sum_q <= sum_q + sqterm;
        rem_q <= '0;
        root_q <= '0;
      end
      OP_SQRT: begin
        // one result bit per step, restoring
        sum_q <= {sum_q[SW-3:0], 2'b00};
        if (!trial[SW-1] && {rem_q[SW-3:0], sum_q[SW-1 -: 2]} >= {30'd0, root_q, 2'b01}) begin
          rem_q  <= trial;
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          rem_q  <= {rem_q[SW-3:0], sum_q[SW-1 -: 2]};
          root_q <= {root_q[30:0], 1'b0};
        end
      end
      OP_DIV_LD: begin
        num_q  <= (NW'(sm_q[cmd_i.comp]) << OUT_FRAC_BITS) + NW'(root_q >> 1);
        drem_q <= '0;
        quo_q  <= '0;
      end
      OP_DIV: begin
        num_q <= {num_q[NW-2:0], 1'b0};
        if (!dtrial[32]) begin
          drem_q <= dtrial[31:0];
          quo_q  <= {quo_q[QW-2:0], 1'b1};
        end else begin
          drem_q <= {drem_q[30:0], num_q[NW-1]};
          quo_q  <= {quo_q[QW-2:0], 1'b0};
        end
      end
      OP_DIV_ST: begin
        res_q[ridx] <= neg_q[cmd_i.comp] ? -16'(qsat) : 16'(qsat);
      end
      OP_OUT: begin
        for (int i = 0; i < 6; i++) res_q[i] <= '0;
      end
      default: ;
    endcase
  end

  assign stat_o.det_zero  = (det_q == '0);
  assign stat_o.vec_zero  = (mx == '0);
  assign res_o = res_q;

endmodule

>>> sv/ttb_ctrl.sv
module ttb_ctrl import ttb_pkg::*; #(
  parameter int unsigned OUT_FRAC_BITS = 14
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output logic  degenerate_o,
  output cmd_t  cmd_o,
  input  stat_t stat_i
);

  localparam int unsigned NW = NORM_TOP + OUT_FRAC_BITS + 1;

  localparam logic [3:0] S_IDLE = 4'd0, S_MUL = 4'd1, S_VEC = 4'd2, S_LD = 4'd3,
                         S_SCALE = 4'd4, S_SUMSQ = 4'd5, S_SQRT = 4'd6,
                         S_DLD = 4'd7, S_DIV = 4'd8, S_DST = 4'd9,
                         S_BAD = 4'd10, S_DONE = 4'd11;

  logic [3:0] st_q, st_d;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] comp_q, comp_d;
  logic       vsel_q, vsel_d;
  logic [5:0] it_q, it_d;
  logic       deg_q, deg_d;
  logic       ov_q, ov_d;
  logic       acc;

  // store beats never touch the waiting result; hold only the third beat
  assign in_ready_o = (st_q == S_IDLE) && !(ov_q && cnt_q == 2'd2);
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; comp_d = comp_q; vsel_d = vsel_q;
    it_d = it_q; deg_d = deg_q; ov_d = ov_q;
    cmd_o = '{op: OP_NONE, vsel: vsel_q, comp: comp_q};
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (st_q)
      S_IDLE: if (acc) begin
        unique case (cnt_q)
          2'd1: begin cmd_o.op = OP_STORE1; cnt_d = 2'd2; end
          2'd2: begin cmd_o.op = OP_DELTA; cnt_d = 2'd0; st_d = S_MUL; end
          default: begin cmd_o.op = OP_STORE0; cnt_d = 2'd1; end
        endcase
      end
      S_MUL: begin cmd_o.op = OP_MUL; st_d = S_VEC; end
      S_VEC: begin
        cmd_o.op = OP_VEC; vsel_d = 1'b0;
        st_d = stat_i.det_zero ? S_BAD : S_LD;
      end
      S_LD: begin cmd_o.op = OP_NORM_LD; st_d = S_SCALE; end
      S_SCALE: begin
        cmd_o.op = OP_SCALE; comp_d = 2'd0;
        st_d = stat_i.vec_zero ? S_BAD : S_SUMSQ;
      end
      S_SUMSQ: begin
        cmd_o.op = OP_SUMSQ;
        if (comp_q == 2'd2) begin comp_d = 2'd0; it_d = 6'd0; st_d = S_SQRT; end
        else comp_d = comp_q + 2'd1;
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT;
        if (it_q == 6'd31) st_d = S_DLD;
        it_d = it_q + 6'd1;
      end
      S_DLD: begin cmd_o.op = OP_DIV_LD; it_d = 6'd0; st_d = S_DIV; end
      S_DIV: begin
        cmd_o.op = OP_DIV;
        if (it_q == 6'(NW - 1)) st_d = S_DST;
        it_d = it_q + 6'd1;
      end
      S_DST: begin
        cmd_o.op = OP_DIV_ST;
        if (comp_q != 2'd2) begin comp_d = comp_q + 2'd1; st_d = S_DLD; end
        else if (!vsel_q) begin vsel_d = 1'b1; st_d = S_LD; end
        else begin deg_d = 1'b0; st_d = S_DONE; end
      end
      S_BAD: begin cmd_o.op = OP_OUT; deg_d = 1'b1; st_d = S_DONE; end
      S_DONE: begin ov_d = 1'b1; st_d = S_IDLE; end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; cnt_q <= '0; comp_q <= '0; vsel_q <= 1'b0;
      it_q <= '0; deg_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; comp_q <= comp_d; vsel_q <= vsel_d;
      it_q <= it_d; deg_q <= deg_d; ov_q <= ov_d;
    end
  end

  assign out_valid_o  = ov_q;
  assign degenerate_o = deg_q;

endmodule

>>> sv/triangle_tangent_bitangent_top.sv
// Triangle tangent-space basis. Send a triangle's vertices one beat each;
// the third beat yields one result beat with unit tangent and bitangent in
// signed Q1.OUT_FRAC_BITS, or zero vectors with degenerate set when the UV
// determinant or a vector is zero. The third beat runs through a sequencer:
// setup (products, vectors), then per vector a load and an alignment step, a
// sum of squares over the three components, a 32-step square root and three
// divisions, each a load, NORM_TOP+OUT_FRAC_BITS+1 (45) restoring steps and a
// store. One triangle is processed at a time; while a result beat waits, the
// first two beats of the next triangle are taken and its third is held.
module triangle_tangent_bitangent_top import ttb_pkg::*; #(
  parameter int unsigned POS_WIDTH     = 32,
  parameter int unsigned UV_WIDTH      = 16,
  parameter int unsigned OUT_FRAC_BITS = 14
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [POS_WIDTH-1:0] pos_x_i,
  input  logic signed [POS_WIDTH-1:0] pos_y_i,
  input  logic signed [POS_WIDTH-1:0] pos_z_i,
  input  logic signed [UV_WIDTH-1:0]  tex_u_i,
  input  logic signed [UV_WIDTH-1:0]  tex_v_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [15:0]          tangent_x_o,
  output logic signed [15:0]          tangent_y_o,
  output logic signed [15:0]          tangent_z_o,
  output logic signed [15:0]          bitangent_x_o,
  output logic signed [15:0]          bitangent_y_o,
  output logic signed [15:0]          bitangent_z_o,
  output logic                        degenerate_o
);

  cmd_t  cmd;
  stat_t stat;
  logic signed [15:0] res [6];

  // Sequence the triangle through the shared datapath
  ttb_ctrl #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .degenerate_o, .cmd_o(cmd), .stat_i(stat)
  );

  // Hold vertices, form deltas and products, normalize
  ttb_datapath #(
    .POS_WIDTH(POS_WIDTH), .UV_WIDTH(UV_WIDTH), .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_dp (
    .clk_i, .cmd_i(cmd), .stat_o(stat), .pos_x_i, .pos_y_i, .pos_z_i,
    .tex_u_i, .tex_v_i, .res_o(res)
  );

  assign tangent_x_o   = res[0];
  assign tangent_y_o   = res[1];
  assign tangent_z_o   = res[2];
  assign bitangent_x_o = res[3];
  assign bitangent_y_o = res[4];
  assign bitangent_z_o = res[5];

endmodule
